// ===== rtl/core/battery_range_level_meter_unit_assert.svh =====
// Assertion macros shared by the battery range level meter RTL.
`ifndef BATTERY_RANGE_LEVEL_METER_UNIT_ASSERT_SVH
`define BATTERY_RANGE_LEVEL_METER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define BRLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define BRLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/brlm_pkg.sv =====
// Constants, types and helper functions of the battery range level meter.
`timescale 1ns / 1ps

package brlm_pkg;

  localparam int LED_COUNT        = 5;
  localparam int STEPS_PER_LED    = 4;
  localparam int HISTORY_DEPTH    = 2;
  localparam int REFRESH_INTERVAL = 16;

  localparam int LEVEL_FULL = LED_COUNT * STEPS_PER_LED;

  localparam int SAMPLE_W = 10;
  localparam int VOLT_W   = 10;
  localparam int LEVEL_W  = 5;
  localparam int CLASS_W  = 3;
  localparam int MODE_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int TICK_W   = 16;

  localparam int OPEN_LO   = 650;
  localparam int OPEN_HI   = 774;
  localparam int VCC_LO    = 640;
  localparam int VCC_HI    = 819;
  localparam int VCC_SLOPE = (256 * (VCC_HI - VCC_LO)) / (OPEN_HI - OPEN_LO);
  localparam int WAKE_LO   = OPEN_LO - 50;
  localparam int WAKE_HI   = OPEN_HI + 50;
  localparam int EST_T_W   = 7;

  localparam int OPEN_VOLT = 25;
  localparam int TH_OPEN   = 4;
  localparam int TH_1V5    = 66;
  localparam int TH_3V0    = 107;
  localparam int TH_3V7    = 179;

  localparam int LV_1V5_LO = 256;
  localparam int LV_1V5_HI = 409;
  localparam int LV_3V0_LO = 640;
  localparam int LV_3V0_HI = 793;
  localparam int LV_3V7_LO = 921;
  localparam int LV_3V7_HI = 1075;
  localparam int LV_9V_LO  = 1792;
  localparam int LV_9V_HI  = 2304;
  localparam int SLOPE_1V5 = (256 * LEVEL_FULL) / (LV_1V5_HI - LV_1V5_LO);
  localparam int SLOPE_3V0 = (256 * LEVEL_FULL) / (LV_3V0_HI - LV_3V0_LO);
  localparam int SLOPE_3V7 = (256 * LEVEL_FULL) / (LV_3V7_HI - LV_3V7_LO);
  localparam int SLOPE_9V  = (256 * LEVEL_FULL) / (LV_9V_HI - LV_9V_LO);

  localparam int PHASE_SHIFT    = 6;
  localparam int PHASE_PERIOD   = LED_COUNT * 64;
  localparam int PHASE_W        = $clog2(PHASE_PERIOD);
  localparam int TICKS_PER_SLOT = 2;
  localparam int TICK_RESET     = 100;
  localparam int BLINK_BIT      = 9;

  localparam int HIST_PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int RC_W       = (REFRESH_INTERVAL > 1) ? $clog2(REFRESH_INTERVAL) : 1;

  // Internal datapath widths.
  localparam int VFX_W   = 14;  // 16x scaled and final volt values
  localparam int LCLIP_W = 10;  // clipped offset inside a level span
  localparam int SLOPE_W = 6;

  localparam logic [MODE_W-1:0] MODE_WAIT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEAS = 2'd2;

  localparam logic [CLASS_W-1:0] CLS_OPEN = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_1V5  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_3V0  = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_3V7  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_9V   = 3'd4;

  typedef struct packed {
    logic load;
    logic est;
    logic diode;
    logic raw;
    logic clip;
    logic scale;
    logic classify;
    logic level;
    logic beat;
  } cmd_t;

  typedef struct packed {
    logic last_slot;
  } status_t;

  function automatic logic [VFX_W-1:0] level_lo(input logic [CLASS_W-1:0] cls);
    logic [VFX_W-1:0] lo;
    case (cls)
      CLS_1V5: lo = VFX_W'(LV_1V5_LO);
      CLS_3V0: lo = VFX_W'(LV_3V0_LO);
      CLS_3V7: lo = VFX_W'(LV_3V7_LO);
      CLS_9V:  lo = VFX_W'(LV_9V_LO);
      default: lo = '0;
    endcase
    return lo;
  endfunction

  function automatic logic [LCLIP_W-1:0] level_span(input logic [CLASS_W-1:0] cls);
    logic [LCLIP_W-1:0] span;
    case (cls)
      CLS_1V5: span = LCLIP_W'(LV_1V5_HI - LV_1V5_LO);
      CLS_3V0: span = LCLIP_W'(LV_3V0_HI - LV_3V0_LO);
      CLS_3V7: span = LCLIP_W'(LV_3V7_HI - LV_3V7_LO);
      CLS_9V:  span = LCLIP_W'(LV_9V_HI - LV_9V_LO);
      default: span = '0;
    endcase
    return span;
  endfunction

  function automatic logic [SLOPE_W-1:0] level_slope(input logic [CLASS_W-1:0] cls);
    logic [SLOPE_W-1:0] slope;
    case (cls)
      CLS_1V5: slope = SLOPE_W'(SLOPE_1V5);
      CLS_3V0: slope = SLOPE_W'(SLOPE_3V0);
      CLS_3V7: slope = SLOPE_W'(SLOPE_3V7);
      CLS_9V:  slope = SLOPE_W'(SLOPE_9V);
      default: slope = '0;
    endcase
    return slope;
  endfunction

endpackage

// ===== rtl/core/brlm_ctrl.sv =====
// Step sequencer and stream handshake control of the level meter.
`timescale 1ns / 1ps

module brlm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  brlm_pkg::status_t status,
  output brlm_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EST   = 9'b000000010,
    ST_DIODE = 9'b000000100,
    ST_RAW   = 9'b000001000,
    ST_CLIP  = 9'b000010000,
    ST_SCALE = 9'b000100000,
    ST_CLASS = 9'b001000000,
    ST_LEVEL = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_EST;
      ST_EST:   state_next = ST_DIODE;
      ST_DIODE: state_next = ST_RAW;
      ST_RAW:   state_next = ST_CLIP;
      ST_CLIP:  state_next = ST_SCALE;
      ST_SCALE: state_next = ST_CLASS;
      ST_CLASS: state_next = ST_LEVEL;
      ST_LEVEL: state_next = ST_OUT;
      ST_OUT:   if (m_tready && status.last_slot) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_IDLE) && s_tvalid;
    cmd.est      = (state == ST_EST);
    cmd.diode    = (state == ST_DIODE);
    cmd.raw      = (state == ST_RAW);
    cmd.clip     = (state == ST_CLIP);
    cmd.scale    = (state == ST_SCALE);
    cmd.classify = (state == ST_CLASS);
    cmd.level    = (state == ST_LEVEL);
    cmd.beat     = (state == ST_OUT) && m_tready;
  end

endmodule

// ===== rtl/core/brlm_dp.sv =====
// Datapath of the level meter: supply estimate, volt conversion, class and bar.
`timescale 1ns / 1ps

module brlm_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  brlm_pkg::cmd_t                      cmd,
  output brlm_pkg::status_t                   status,
  input  logic [brlm_pkg::SAMPLE_W-1:0]       sample_in,
  output logic [brlm_pkg::SLOT_W-1:0]         slot_led,
  output logic                                led_on,
  output logic [brlm_pkg::LEVEL_W-1:0]        bar_level,
  output logic [brlm_pkg::CLASS_W-1:0]        battery_class,
  output logic [brlm_pkg::MODE_W-1:0]         mode_now,
  output logic [brlm_pkg::VOLT_W-1:0]         supply_estimate
);

  // Architectural state.
  logic [brlm_pkg::MODE_W-1:0]     mode_reg;
  logic [brlm_pkg::CLASS_W-1:0]    battery_range;
  logic [brlm_pkg::VOLT_W-1:0]     supply_volts;
  logic [brlm_pkg::VOLT_W-1:0]     diode_drop_volts;
  logic [brlm_pkg::SAMPLE_W-1:0]   open_history [brlm_pkg::HISTORY_DEPTH];
  logic [brlm_pkg::HIST_PTR_W-1:0] history_pointer;
  logic [brlm_pkg::RC_W-1:0]       refresh_counter;
  logic [brlm_pkg::PHASE_W-1:0]    pwm_phase;
  logic [brlm_pkg::TICK_W-1:0]     tick_count;

  // Per-item working registers.
  logic [brlm_pkg::SAMPLE_W-1:0]   sample;
  logic [brlm_pkg::SAMPLE_W-1:0]   est_src;
  logic                            est_upd;
  logic                            wake_hit;
  logic [brlm_pkg::VFX_W-1:0]      raw_volts;
  logic [brlm_pkg::VFX_W-1:0]      clip_volts;
  logic [brlm_pkg::VFX_W-1:0]      volts;
  logic [brlm_pkg::CLASS_W-1:0]    lvl_cls;
  logic [brlm_pkg::LCLIP_W-1:0]    lvl_clip;
  logic [brlm_pkg::SLOPE_W-1:0]    lvl_slope;
  logic [brlm_pkg::LEVEL_W-1:0]    level_reg;
  logic [2:0]                      bright_phase;
  logic [brlm_pkg::SLOT_W-1:0]     slot_idx;

  logic is_open;
  logic is_meas;
  logic is_wait;

  assign is_open = (mode_reg == brlm_pkg::MODE_OPEN);
  assign is_meas = (mode_reg == brlm_pkg::MODE_MEAS);
  assign is_wait = !is_open && !is_meas;

  // Supply estimate step.
  logic                            refresh_hit;
  logic                            wake_range;
  logic                            refresh_upd;
  logic                            wake_upd;
  logic [brlm_pkg::SAMPLE_W-1:0]   hist_min;
  logic [brlm_pkg::SAMPLE_W-1:0]   est_in;
  logic [brlm_pkg::SAMPLE_W-1:0]   est_diff;
  logic [brlm_pkg::EST_T_W-1:0]    est_t;
  logic [15:0]                     est_prod;
  logic [brlm_pkg::VOLT_W-1:0]     est_supply;
  logic [brlm_pkg::HIST_PTR_W-1:0] ptr_inc;

  assign refresh_hit = (refresh_counter == brlm_pkg::RC_W'(brlm_pkg::REFRESH_INTERVAL - 1));
  assign wake_range  = (sample >= brlm_pkg::SAMPLE_W'(brlm_pkg::WAKE_LO)) &&
                       (sample <  brlm_pkg::SAMPLE_W'(brlm_pkg::WAKE_HI));
  assign refresh_upd = is_open && refresh_hit;
  assign wake_upd    = is_wait && wake_range;

  always_comb begin
    hist_min = sample;
    for (int i = 0; i < brlm_pkg::HISTORY_DEPTH; i++) begin
      if (open_history[i] < hist_min) hist_min = open_history[i];
    end
  end

  assign est_in   = is_open ? hist_min : sample;
  assign est_diff = brlm_pkg::SAMPLE_W'(brlm_pkg::OPEN_HI) - est_in;

  always_comb begin
    if (est_in > brlm_pkg::SAMPLE_W'(brlm_pkg::OPEN_HI)) begin
      est_t = '0;
    end else if (est_in < brlm_pkg::SAMPLE_W'(brlm_pkg::OPEN_LO)) begin
      est_t = brlm_pkg::EST_T_W'(brlm_pkg::OPEN_HI - brlm_pkg::OPEN_LO);
    end else begin
      est_t = est_diff[brlm_pkg::EST_T_W-1:0];
    end
  end

  assign est_prod   = 16'(brlm_pkg::VCC_SLOPE) * {9'd0, est_t};
  assign est_supply = {2'd0, est_prod[15:8]} + brlm_pkg::VOLT_W'(brlm_pkg::VCC_LO);

  always_comb begin
    if ((32'(history_pointer) + 32'd1) >= 32'(brlm_pkg::HISTORY_DEPTH)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = history_pointer + 1'b1;
    end
  end

  // Diode drop and raw volt products.
  logic [19:0] diode_prod;
  logic [19:0] raw_prod;

  assign diode_prod = {10'd0, supply_volts} * {10'd0, est_src};
  assign raw_prod   = {10'd0, sample} * {10'd0, supply_volts};

  // Offset clip of the raw reading, in 16x units.
  logic [brlm_pkg::VFX_W-1:0] drop16;
  logic [10:0]                span_diff;
  logic [brlm_pkg::VFX_W-1:0] span16;
  logic [brlm_pkg::VFX_W:0]   off_diff;
  logic [brlm_pkg::VFX_W-1:0] clip_next;

  assign drop16    = {diode_drop_volts, 4'd0};
  assign span_diff = {1'b0, supply_volts} - {1'b0, diode_drop_volts};
  assign span16    = span_diff[10] ? '0 : {span_diff[9:0], 4'd0};
  assign off_diff  = {1'b0, raw_volts} - {1'b0, drop16};

  always_comb begin
    if (off_diff[brlm_pkg::VFX_W]) begin
      clip_next = '0;
    end else if (off_diff[brlm_pkg::VFX_W-1:0] > span16) begin
      clip_next = span16;
    end else begin
      clip_next = off_diff[brlm_pkg::VFX_W-1:0];
    end
  end

  // Divider ratio scaling by 11/16.
  logic [17:0] scale_prod;

  assign scale_prod = {4'd0, clip_volts} * 18'd11;

  // Classification and offset into the class span.
  logic [10:0]                  quarter;
  logic [brlm_pkg::CLASS_W-1:0] cls_q;
  logic [brlm_pkg::CLASS_W-1:0] cls_sel;
  logic [brlm_pkg::VFX_W-1:0]   lvl_val;
  logic [brlm_pkg::VFX_W-1:0]   lvl_lo;
  logic [brlm_pkg::LCLIP_W-1:0] lvl_span;
  logic [brlm_pkg::VFX_W:0]     lvl_diff;
  logic [brlm_pkg::LCLIP_W-1:0] lvl_clip_next;

  assign quarter = volts[brlm_pkg::VFX_W-1:3];

  always_comb begin
    if (quarter < 11'(brlm_pkg::TH_OPEN)) begin
      cls_q = brlm_pkg::CLS_OPEN;
    end else if (quarter < 11'(brlm_pkg::TH_1V5)) begin
      cls_q = brlm_pkg::CLS_1V5;
    end else if (quarter < 11'(brlm_pkg::TH_3V0)) begin
      cls_q = brlm_pkg::CLS_3V0;
    end else if (quarter < 11'(brlm_pkg::TH_3V7)) begin
      cls_q = brlm_pkg::CLS_3V7;
    end else begin
      cls_q = brlm_pkg::CLS_9V;
    end
  end

  // In open mode the bar shows the supply on the 3V scale.
  assign cls_sel  = is_meas ? cls_q : brlm_pkg::CLS_3V0;
  assign lvl_val  = is_meas ? volts : {4'd0, supply_volts};
  assign lvl_lo   = brlm_pkg::level_lo(cls_sel);
  assign lvl_span = brlm_pkg::level_span(cls_sel);
  assign lvl_diff = {1'b0, lvl_val} - {1'b0, lvl_lo};

  always_comb begin
    if (lvl_diff[brlm_pkg::VFX_W]) begin
      lvl_clip_next = '0;
    end else if (lvl_diff[brlm_pkg::VFX_W-1:0] > {4'd0, lvl_span}) begin
      lvl_clip_next = lvl_span;
    end else begin
      lvl_clip_next = lvl_diff[brlm_pkg::LCLIP_W-1:0];
    end
  end

  // Bar level from slope and offset.
  logic [15:0]                  lvl_prod;
  logic [8:0]                   lvl_sum;
  logic [brlm_pkg::LEVEL_W-1:0] lvl_capped;
  logic [brlm_pkg::LEVEL_W-1:0] level_next;

  assign lvl_prod   = {10'd0, lvl_slope} * {6'd0, lvl_clip};
  assign lvl_sum    = {1'b0, lvl_prod[15:8]} + 9'd1;
  assign lvl_capped = (lvl_sum > 9'(brlm_pkg::LEVEL_FULL)) ?
                      brlm_pkg::LEVEL_W'(brlm_pkg::LEVEL_FULL) : lvl_sum[brlm_pkg::LEVEL_W-1:0];

  always_comb begin
    if (is_wait) begin
      level_next = tick_count[brlm_pkg::BLINK_BIT] ?
                   brlm_pkg::LEVEL_W'(brlm_pkg::LEVEL_FULL) : '0;
    end else begin
      case (lvl_cls) inside
        brlm_pkg::CLS_1V5, brlm_pkg::CLS_3V0, brlm_pkg::CLS_3V7, brlm_pkg::CLS_9V:
          level_next = lvl_capped;
        default:
          level_next = brlm_pkg::LEVEL_W'(1);
      endcase
    end
  end

  // Control state: modes, counters and brightness timing.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= brlm_pkg::MODE_WAIT;
      history_pointer <= '0;
      refresh_counter <= '0;
      pwm_phase       <= '0;
      tick_count      <= brlm_pkg::TICK_W'(brlm_pkg::TICK_RESET);
    end else begin
      if (cmd.est) begin
        if (is_open) begin
          refresh_counter <= refresh_hit ? '0 : refresh_counter + 1'b1;
        end
        if (refresh_upd) begin
          history_pointer <= ptr_inc;
        end
      end
      if (cmd.level) begin
        if (is_open && (volts >= brlm_pkg::VFX_W'(brlm_pkg::OPEN_VOLT))) begin
          mode_reg <= brlm_pkg::MODE_MEAS;
        end else if (is_meas && (lvl_cls == brlm_pkg::CLS_OPEN)) begin
          mode_reg <= brlm_pkg::MODE_OPEN;
        end else if (is_wait && wake_hit) begin
          mode_reg <= brlm_pkg::MODE_OPEN;
        end
      end
      if (cmd.beat) begin
        tick_count <= tick_count + brlm_pkg::TICK_W'(brlm_pkg::TICKS_PER_SLOT);
        if ((32'(pwm_phase) + 32'd1) < 32'(brlm_pkg::PHASE_PERIOD)) begin
          pwm_phase <= pwm_phase + 1'b1;
        end else begin
          pwm_phase <= '0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= sample_in;
    end
    if (cmd.est) begin
      est_src  <= est_in;
      est_upd  <= refresh_upd || wake_upd;
      wake_hit <= wake_range;
      if (refresh_upd || wake_upd) begin
        supply_volts <= est_supply;
      end
      if (refresh_upd) begin
        open_history[ptr_inc] <= sample;
      end
      if (wake_upd) begin
        for (int i = 0; i < brlm_pkg::HISTORY_DEPTH; i++) begin
          open_history[i] <= sample;
        end
      end
    end
    if (cmd.diode && est_upd) begin
      diode_drop_volts <= diode_prod[19:10];
    end
    if (cmd.raw) begin
      raw_volts <= raw_prod[19:6];
    end
    if (cmd.clip) begin
      clip_volts <= clip_next;
    end
    if (cmd.scale) begin
      volts <= scale_prod[17:4];
    end
    if (cmd.classify) begin
      lvl_cls   <= cls_sel;
      lvl_clip  <= lvl_clip_next;
      lvl_slope <= brlm_pkg::level_slope(cls_sel);
    end
    if (cmd.level) begin
      level_reg    <= level_next;
      bright_phase <= 3'(pwm_phase >> brlm_pkg::PHASE_SHIFT);
      slot_idx     <= '0;
      if (is_meas) begin
        battery_range <= lvl_cls;
      end
    end
    if (cmd.beat) begin
      slot_idx <= slot_idx + 1'b1;
    end
  end

  // Slot outputs: LEDs are sent from the highest index down.
  logic [7:0] led_base;
  logic [7:0] led_excess;
  logic [7:0] led_fill;

  assign slot_led   = brlm_pkg::SLOT_W'(brlm_pkg::LED_COUNT - 1) - slot_idx;
  assign led_base   = 8'(brlm_pkg::STEPS_PER_LED) * {5'd0, slot_led};
  assign led_excess = {3'd0, level_reg} - led_base;

  always_comb begin
    if ({3'd0, level_reg} <= led_base) begin
      led_fill = '0;
    end else if (led_excess > 8'(brlm_pkg::STEPS_PER_LED)) begin
      led_fill = 8'(brlm_pkg::STEPS_PER_LED);
    end else begin
      led_fill = led_excess;
    end
  end

  assign led_on           = ({5'd0, bright_phase} < led_fill);
  assign bar_level        = level_reg;
  assign battery_class    = battery_range;
  assign mode_now         = mode_reg;
  assign supply_estimate  = supply_volts;
  assign status.last_slot = (slot_idx == brlm_pkg::SLOT_W'(brlm_pkg::LED_COUNT - 1));

endmodule

// ===== rtl/core/battery_range_level_meter_unit.sv =====
// Usage notes:
// The slave stream takes one averaged probe reading per beat in s_tdata[9:0].
// Each reading yields five master beats, one per LED time slot, LED 4 first
// and LED 0 last; m_tlast marks the fifth beat of the reading.
// The sequencer runs one reading at a time: s_tready is high only while idle.
// After the accepting edge, seven steps follow in order (supply estimate,
// diode drop, raw product, offset clip, divider scaling, class, bar level),
// and the first slot beat is offered after the bar level step.
// A stall on the master side lengthens the item, since no new reading is
// accepted until the last slot beat of the current one is taken.
// A stalled slot beat holds its data until it is taken.
// Reset (rst, synchronous, active high) returns to the wait-for-open mode
// with the bar timing counters at their start values; the supply estimate
// and history are undefined until the first open-probe reading, and the
// class until the first measurement.
`timescale 1ns / 1ps

module battery_range_level_meter_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] probe_sample, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] slot_led, [3] led_on, [8:4] bar_level, [11:9] battery_class,
  // [13:12] mode_now, [23:14] supply_estimate
  output logic [23:0] m_tdata,
  output logic        m_tlast    // last_slot
);

  `include "battery_range_level_meter_unit_assert.svh"

  brlm_pkg::cmd_t    cmd;
  brlm_pkg::status_t status;

  logic [brlm_pkg::SLOT_W-1:0]  slot_led;
  logic                         led_on;
  logic [brlm_pkg::LEVEL_W-1:0] bar_level;
  logic [brlm_pkg::CLASS_W-1:0] battery_class;
  logic [brlm_pkg::MODE_W-1:0]  mode_now;
  logic [brlm_pkg::VOLT_W-1:0]  supply_estimate;

  brlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  brlm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .sample_in       (s_tdata[brlm_pkg::SAMPLE_W-1:0]),
    .slot_led        (slot_led),
    .led_on          (led_on),
    .bar_level       (bar_level),
    .battery_class   (battery_class),
    .mode_now        (mode_now),
    .supply_estimate (supply_estimate)
  );

  assign m_tdata = {supply_estimate, mode_now, battery_class, bar_level, led_on, slot_led};
  assign m_tlast = status.last_slot;

  `BRLM_ASSERT_IMP(a_no_overlap, s_tready, !m_tvalid, "input accepted while slot beats pending")
  `BRLM_ASSERT_NXT(a_last_to_idle, m_tvalid && m_tready && m_tlast, s_tready,
                   "sequencer did not return to idle after the final slot beat")
  `BRLM_ASSERT_IMP(a_last_is_led0, m_tvalid && m_tlast, m_tdata[2:0] == 3'd0,
                   "final slot beat does not drive LED 0")
  `BRLM_ASSERT_IMP(a_mode_code, m_tvalid, m_tdata[13:12] != 2'd3,
                   "unused mode code reported on a slot beat")

endmodule
